[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while i_rst_n low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NHC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NHC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/nhc_pkg.sv]
// ---------------------------------------------------------------------------
// nhc_pkg
// Types, constants and tables of the chain thermostat.
// ---------------------------------------------------------------------------
`default_nettype none

package nhc_pkg;

    localparam int DOF_BITS   = 10;
    localparam int CHAIN_BITS = 3;
    localparam int CHAIN_MAX  = 1 << CHAIN_BITS;
    localparam int MEM_ABITS  = DOF_BITS + CHAIN_BITS;
    localparam int MEM_DEPTH  = 1 << MEM_ABITS;

    // configuration register indexes
    localparam logic [2:0] CFG_KT        = 3'd0;
    localparam logic [2:0] CFG_ICM       = 3'd1;
    localparam logic [2:0] CFG_STEP_W    = 3'd2;
    localparam logic [2:0] CFG_SY_ORDER  = 3'd3;
    localparam logic [2:0] CFG_NH_STEPS  = 3'd4;
    localparam logic [2:0] CFG_CHAIN_LEN = 3'd5;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

    // range reduction for exp: x = k*ln2 + r
    localparam logic [15:0] LN2_Q16   = 16'd45426;
    localparam logic [16:0] EXP_KOFS  = 17'd47276;
    localparam logic [32:0] EXP_YOFS  = 33'(64'd47276 * 64'd45426);
    localparam logic [35:0] EXP_RECIP = 36'((64'd1 << 48) / 64'd45426);
    localparam logic [32:0] ONE_Q30   = 33'h0_4000_0000;

    localparam logic [63:0] RCP_NUM = 64'h0000_000F_FFFF_FFFF;
    localparam logic [35:0] RCP_1 = 36'(RCP_NUM);
    localparam logic [35:0] RCP_2 = 36'(RCP_NUM / 2);
    localparam logic [35:0] RCP_3 = 36'(RCP_NUM / 3);
    localparam logic [35:0] RCP_4 = 36'(RCP_NUM / 4);
    localparam logic [35:0] RCP_5 = 36'(RCP_NUM / 5);
    localparam logic [35:0] RCP_6 = 36'(RCP_NUM / 6);
    localparam logic [35:0] RCP_7 = 36'(RCP_NUM / 7);
    localparam logic [35:0] RCP_8 = 36'(RCP_NUM / 8);

    function automatic logic [35:0] div_recip(input logic [3:0] n);
        logic [35:0] r;
        case (n)
            4'd1:    r = RCP_1;
            4'd2:    r = RCP_2;
            4'd3:    r = RCP_3;
            4'd4:    r = RCP_4;
            4'd5:    r = RCP_5;
            4'd6:    r = RCP_6;
            4'd7:    r = RCP_7;
            default: r = RCP_8;
        endcase
        return r;
    endfunction

    // Suzuki-Yoshida weights, signed Q2.30
    localparam logic signed [31:0] SY_ROM [32] = '{
        32'sd1073741824,
        32'sd1450847675, -32'sd1827953526, 32'sd1450847675,
        32'sd445056077, 32'sd445056077, -32'sd706482484, 32'sd445056077, 32'sd445056077,
        32'sd842365075, 32'sd252944812, -32'sd1264524254, 32'sd1412170558,
        -32'sd1264524254, 32'sd252944812, 32'sd842365075,
        32'sd206158430, 32'sd595830954, 32'sd133852248, -32'sd905359847,
        32'sd1012778254, -32'sd905359847, 32'sd133852248, 32'sd595830954,
        32'sd206158430,
        32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0
    };
    localparam logic [4:0] SY_START [8] = '{5'd0, 5'd1, 5'd4, 5'd9, 5'd16, 5'd16, 5'd16, 5'd16};
    localparam logic [3:0] SY_LAST  [8] = '{4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd8, 4'd8, 4'd8};

    typedef enum logic [5:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD,
        ST_W0, ST_W1, ST_W2, ST_W3, ST_W4, ST_W5, ST_W6,
        ST_LA, ST_LB, ST_LC, ST_LW, ST_LE,
        ST_FA, ST_FB, ST_FC, ST_FD, ST_FE, ST_FF, ST_FG,
        ST_PA, ST_PB, ST_PW, ST_PD,
        ST_XA, ST_XB, ST_XC,
        ST_NEXT, ST_STORE, ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        EX_IDLE, EX_RED, EX_QUO, EX_HMUL, EX_HDIV, EX_HFIX, EX_SHIFT
    } t_exp_state;

endpackage

`default_nettype wire

[rtl/core/nhc_ram.sv]
// ---------------------------------------------------------------------------
// nhc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module nhc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/nhc_qmul.sv]
// ---------------------------------------------------------------------------
// nhc_qmul
// Shared fixed-point multiplier: round half away from zero, saturate, register.
// ---------------------------------------------------------------------------
`default_nettype none

module nhc_qmul import nhc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [32:0] i_b,
    input  wire logic               i_shift30,
    output logic signed [31:0]      o_res
);

    logic        neg;
    logic [32:0] na, nb;
    logic [31:0] ma, mb;
    logic [63:0] prod;
    logic [64:0] sum;
    logic [48:0] mag;
    logic signed [31:0] n_res;
    logic signed [31:0] r_res;

    always_comb begin
        neg  = i_a[32] ^ i_b[32];
        na   = -i_a;
        nb   = -i_b;
        ma   = i_a[32] ? na[31:0] : i_a[31:0];
        mb   = i_b[32] ? nb[31:0] : i_b[31:0];
        prod = ma * mb;
        sum  = {1'b0, prod} + (i_shift30 ? 65'd536870912 : 65'd32768);
        mag  = i_shift30 ? {14'd0, sum[64:30]} : sum[64:16];
        if (neg) begin
            n_res = (mag > 49'h0_0000_8000_0000) ? Q_MIN : -$signed(mag[31:0]);
        end else begin
            n_res = (mag > 49'h0_0000_7FFF_FFFF) ? Q_MAX : $signed(mag[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[rtl/core/nhc_exp.sv]
// ---------------------------------------------------------------------------
// nhc_exp
// Iterative exp: range reduction by ln2, 8-term Horner series, final shift.
// ---------------------------------------------------------------------------
`default_nettype none

module nhc_exp import nhc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_x,
    output logic                    o_done,
    output logic [31:0]             o_f
);

    t_exp_state r_state, n_state;

    logic [32:0] r_y;
    logic [71:0] r_prod;
    logic signed [17:0] r_k;
    logic [29:0] r_r30;
    logic [32:0] r_t;
    logic [32:0] r_v;
    logic [3:0]  r_n;
    logic        r_done;
    logic [31:0] r_f;

    logic [35:0] mul_a, mul_b;
    logic [71:0] mul_p;
    logic [16:0] qe, qc;
    logic [33:0] rem1;
    logic [15:0] rc;
    logic [32:0] vq;
    logic [35:0] dq, dq_fix, drem;
    logic [17:0] sh_full;
    logic [5:0]  sh;
    logic [63:0] rnd, shv;
    logic [31:0] fval;

    always_comb begin
        unique case (r_state)
            EX_RED:  begin mul_a = {3'd0, r_y};  mul_b = EXP_RECIP; end
            EX_HMUL: begin mul_a = {3'd0, r_t};  mul_b = {6'd0, r_r30}; end
            EX_HDIV: begin mul_a = {3'd0, vq};   mul_b = div_recip(r_n); end
            default: begin mul_a = '0;           mul_b = '0; end
        endcase
        mul_p = mul_a * mul_b;

        qe   = r_prod[64:48];
        rem1 = {1'b0, r_y} - 34'(qe * LN2_Q16);
        if (rem1 >= {18'd0, LN2_Q16}) begin
            qc = qe + 17'd1;
            rc = 16'(rem1 - {18'd0, LN2_Q16});
        end else begin
            qc = qe;
            rc = rem1[15:0];
        end

        vq     = r_prod[62:30];
        dq     = r_prod[71:36];
        drem   = {3'd0, r_v} - 36'(dq * r_n);
        dq_fix = (drem >= {32'd0, r_n}) ? dq + 36'd1 : dq;

        sh_full = 18'sd14 - r_k;
        sh      = sh_full[5:0];
        rnd     = (sh == 6'd0) ? 64'd0 : (64'd1 << (sh - 6'd1));
        shv     = ({31'd0, r_t} + rnd) >> sh;
        if (r_k > 18'sd14) begin
            fval = 32'h7FFF_FFFF;
        end else if (r_k < -18'sd48) begin
            fval = 32'd0;
        end else if (shv > 64'h7FFF_FFFF) begin
            fval = 32'h7FFF_FFFF;
        end else begin
            fval = shv[31:0];
        end

        n_state = r_state;
        unique case (r_state)
            EX_IDLE:  if (i_start) n_state = EX_RED;
            EX_RED:   n_state = EX_QUO;
            EX_QUO:   n_state = EX_HMUL;
            EX_HMUL:  n_state = EX_HDIV;
            EX_HDIV:  n_state = EX_HFIX;
            EX_HFIX:  n_state = (r_n == 4'd1) ? EX_SHIFT : EX_HMUL;
            EX_SHIFT: n_state = EX_IDLE;
            default:  n_state = EX_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= EX_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == EX_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            EX_IDLE: begin
                r_y <= 33'($signed(i_x)) + EXP_YOFS;
            end
            EX_RED, EX_HMUL: begin
                r_prod <= mul_p;
            end
            EX_QUO: begin
                r_k   <= $signed({1'b0, qc}) - $signed({1'b0, EXP_KOFS});
                r_r30 <= {rc, 14'd0};
                r_t   <= ONE_Q30;
                r_n   <= 4'd8;
            end
            EX_HDIV: begin
                r_v    <= vq;
                r_prod <= mul_p;
            end
            EX_HFIX: begin
                r_t <= ONE_Q30 + dq_fix[32:0];
                r_n <= r_n - 4'd1;
            end
            EX_SHIFT: begin
                r_f <= fval;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_f    = r_f;

endmodule

`default_nettype wire

[rtl/core/nose_hoover_chain_thermostat.sv]
// ---------------------------------------------------------------------------
// nose_hoover_chain_thermostat
// Nose-Hoover chain thermostat with Suzuki-Yoshida substeps, Q16.16.
// ---------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   tvalid / tready         dof_index, momentum_in, inverse_mass
//  m_axis    out  tvalid / tready         momentum_out, position_total
//  cfg       in   wen (no wait)           idx, data
//
// After reset the chain store (8192 words) is cleared; s_axis is not ready meanwhile.
// Each exp call holds the sequencer until the exp unit is done, and every
// sequencer product goes through the one shared multiplier, one per cycle.
// A new item is taken while the previous result still waits on m_axis;
// the result stage stalls the sequencer only if it is still full at the end.
// ---------------------------------------------------------------------------
`default_nettype none

module nose_hoover_chain_thermostat import nhc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [9:0] dof_index, [41:10] momentum_in, [73:42] inverse_mass, [79:74] zero
    input  wire logic [79:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [31:0] momentum_out, [79:32] position_total
    output logic [79:0]      o_m_axis_tdata,
    input  wire logic        i_cfg_wen,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

`include "assert_macros.svh"

    t_state r_state, n_state;

    logic [31:0] r_kt, r_icm, r_sw;
    logic [2:0]  r_sy_order;
    logic [4:0]  r_nh_steps;
    logic [3:0]  r_chain_len;

    logic [DOF_BITS-1:0]   r_dof;
    logic signed [31:0]    r_p;
    logic [31:0]           r_im;
    logic [CHAIN_BITS-1:0] r_last, r_link;
    logic [2:0]            r_sel;
    logic [4:0]            r_reps, r_rep;
    logic [3:0]            r_sub;
    logic [MEM_ABITS-1:0]  r_cnt;
    logic                  r_fwd;

    logic signed [31:0] r_q [CHAIN_MAX];
    logic signed [31:0] r_w, r_fscale, r_fshift, r_fpart, r_fpos, r_force, r_fe;
    logic signed [47:0] r_acc;

    logic        r_out_valid;
    logic [31:0] r_out_mom;
    logic [47:0] r_out_pos;

    logic [CHAIN_BITS-1:0] qidx;
    logic signed [31:0]    q_rd;
    logic signed [32:0]    mul_a, mul_b;
    logic                  mul_s30;
    logic signed [31:0]    mres;
    logic                  exp_start, exp_done;
    logic [31:0]           exp_f;
    logic                  mem_we;
    logic [MEM_ABITS-1:0]  mem_waddr, mem_raddr;
    logic [31:0]           mem_wdata, mem_rdata;

    logic [3:0]            clamp_n;
    logic [CHAIN_BITS-1:0] lk_idx;
    t_state                lk_state;
    logic signed [33:0]    fdiff;
    logic signed [31:0]    fsat;
    logic signed [32:0]    qsum;
    logic signed [31:0]    qsat;
    logic signed [48:0]    asum;
    logic signed [47:0]    asat;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kt        <= 32'd65536;
            r_icm       <= 32'd65536;
            r_sw        <= 32'd655;
            r_sy_order  <= 3'd0;
            r_nh_steps  <= 5'd1;
            r_chain_len <= 4'd4;
        end else if (i_cfg_wen) begin
            if (i_cfg_idx == CFG_KT)        r_kt        <= i_cfg_data;
            if (i_cfg_idx == CFG_ICM)       r_icm       <= i_cfg_data;
            if (i_cfg_idx == CFG_STEP_W)    r_sw        <= i_cfg_data;
            if (i_cfg_idx == CFG_SY_ORDER)  r_sy_order  <= i_cfg_data[2:0];
            if (i_cfg_idx == CFG_NH_STEPS)  r_nh_steps  <= i_cfg_data[4:0];
            if (i_cfg_idx == CFG_CHAIN_LEN) r_chain_len <= i_cfg_data[3:0];
        end
    end

    nhc_qmul u_qmul (
        .i_clk     (i_clk),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .i_shift30 (mul_s30),
        .o_res     (mres)
    );

    nhc_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (exp_start),
        .i_x     (mres),
        .o_done  (exp_done),
        .o_f     (exp_f)
    );

    nhc_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_chain_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        unique case (r_state)
            ST_LA:    qidx = r_link + 1'b1;
            ST_FA:    qidx = r_link - 1'b1;
            ST_PA:    qidx = '0;
            ST_STORE: qidx = r_cnt[CHAIN_BITS-1:0];
            default:  qidx = r_link;
        endcase
        q_rd = r_q[qidx];

        mul_s30 = (r_state == ST_W0);
        unique case (r_state)
            ST_W0: begin
                mul_a = {SY_ROM[SY_START[r_sel] + 5'(r_sub)][31],
                         SY_ROM[SY_START[r_sel] + 5'(r_sub)]};
                mul_b = {1'b0, r_sw};
            end
            ST_W1:   begin mul_a = {mres[31], mres};   mul_b = -33'sd8192; end
            ST_W2:   begin mul_a = {r_w[31], r_w};     mul_b = 33'sd16384; end
            ST_W3:   begin mul_a = {r_w[31], r_w};     mul_b = -33'sd32768; end
            ST_W4:   begin mul_a = {mres[31], mres};   mul_b = {1'b0, r_icm}; end
            ST_W5:   begin mul_a = {r_w[31], r_w};     mul_b = 33'sd32768; end
            ST_LA:   begin mul_a = {r_fscale[31], r_fscale}; mul_b = {q_rd[31], q_rd}; end
            ST_LB:   begin mul_a = {mres[31], mres};   mul_b = {1'b0, r_icm}; end
            ST_LW:   begin mul_a = {q_rd[31], q_rd};   mul_b = {1'b0, exp_f}; end
            ST_FA: begin
                mul_a = (r_link == '0) ? {r_p[31], r_p} : {q_rd[31], q_rd};
                mul_b = mul_a;
            end
            ST_FB: begin
                mul_a = {mres[31], mres};
                mul_b = (r_link == '0) ? {1'b0, r_im} : {1'b0, r_icm};
            end
            ST_FD:   begin mul_a = {r_fshift[31], r_fshift}; mul_b = {r_force[31], r_force}; end
            ST_FF:   begin mul_a = {q_rd[31], q_rd};   mul_b = {r_fe[31], r_fe}; end
            ST_PA:   begin mul_a = {r_fpart[31], r_fpart}; mul_b = {q_rd[31], q_rd}; end
            ST_PW:   begin mul_a = {r_p[31], r_p};     mul_b = {1'b0, exp_f}; end
            ST_XA:   begin mul_a = {q_rd[31], q_rd};   mul_b = {1'b0, r_icm}; end
            ST_XB:   begin mul_a = {mres[31], mres};   mul_b = {r_fpos[31], r_fpos}; end
            default: begin mul_a = '0;                 mul_b = '0; end
        endcase

        exp_start = (r_state == ST_LC) || (r_state == ST_PB);

        mem_we    = (r_state == ST_CLEAR) || (r_state == ST_STORE);
        mem_waddr = (r_state == ST_CLEAR) ? r_cnt : {r_dof, r_cnt[CHAIN_BITS-1:0]};
        mem_wdata = (r_state == ST_CLEAR) ? 32'd0 : q_rd;
        mem_raddr = {r_dof, r_cnt[CHAIN_BITS-1:0]};

        // saturating arithmetic of the link and accumulator updates
        fdiff = 34'(mres) - $signed({2'b00, r_kt});
        if (fdiff > 34'(Q_MAX))      fsat = Q_MAX;
        else if (fdiff < 34'(Q_MIN)) fsat = Q_MIN;
        else                         fsat = fdiff[31:0];
        qsum = 33'(q_rd) + 33'(mres);
        if (qsum > 33'(Q_MAX))      qsat = Q_MAX;
        else if (qsum < 33'(Q_MIN)) qsat = Q_MIN;
        else                        qsat = qsum[31:0];
        asum = 49'(r_acc) + 49'(mres);
        if (asum > 49'(ACC_MAX))      asat = ACC_MAX;
        else if (asum < 49'(ACC_MIN)) asat = ACC_MIN;
        else                          asat = asum[47:0];

        // next link after the current one finishes
        if (r_fwd) begin
            lk_idx   = r_link + 1'b1;
            lk_state = (r_link == r_last) ? ST_NEXT :
                       ((lk_idx == r_last) ? ST_FA : ST_LA);
        end else begin
            lk_idx   = r_link - 1'b1;
            lk_state = (r_link == '0) ? ST_PA : ST_LA;
        end

        if (r_chain_len == 4'd0)             clamp_n = 4'd1;
        else if (r_chain_len > 4'(CHAIN_MAX)) clamp_n = 4'(CHAIN_MAX);
        else                                 clamp_n = r_chain_len;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_cnt == MEM_ABITS'(MEM_DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_s_axis_tvalid) n_state = ST_LOAD;
            ST_LOAD: begin
                if (r_cnt[CHAIN_BITS] == 1'b1) begin
                    n_state = (r_reps == 5'd0) ? ST_STORE : ST_W0;
                end
            end
            ST_W0:   n_state = ST_W1;
            ST_W1:   n_state = ST_W2;
            ST_W2:   n_state = ST_W3;
            ST_W3:   n_state = ST_W4;
            ST_W4:   n_state = ST_W5;
            ST_W5:   n_state = ST_W6;
            ST_W6:   n_state = ST_FA;
            ST_LA:   n_state = ST_LB;
            ST_LB:   n_state = ST_LC;
            ST_LC:   n_state = ST_LW;
            ST_LW:   if (exp_done) n_state = ST_LE;
            ST_LE:   n_state = ST_FA;
            ST_FA:   n_state = ST_FB;
            ST_FB:   n_state = ST_FC;
            ST_FC:   n_state = ST_FD;
            ST_FD:   n_state = ST_FE;
            ST_FE:   n_state = (r_link == r_last) ? lk_state : ST_FF;
            ST_FF:   n_state = ST_FG;
            ST_FG:   n_state = lk_state;
            ST_PA:   n_state = ST_PB;
            ST_PB:   n_state = ST_PW;
            ST_PW:   if (exp_done) n_state = ST_PD;
            ST_PD:   n_state = ST_XA;
            ST_XA:   n_state = ST_XB;
            ST_XB:   n_state = ST_XC;
            ST_XC: begin
                if (r_link != r_last)      n_state = ST_XA;
                else if (r_last == '0)     n_state = ST_FA;
                else                       n_state = ST_LA;
            end
            ST_NEXT: begin
                if (r_sub == SY_LAST[r_sel] && r_rep == r_reps - 5'd1) n_state = ST_STORE;
                else                                                   n_state = ST_W0;
            end
            ST_STORE: if (r_cnt[CHAIN_BITS-1:0] == CHAIN_BITS'(CHAIN_MAX - 1)) n_state = ST_DONE;
            ST_DONE:  if (!r_out_valid || i_m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer counters and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_link <= '0;
            r_fwd  <= 1'b0;
            r_sub  <= '0;
            r_rep  <= '0;
            r_acc  <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: r_cnt <= r_cnt + 1'b1;
                ST_IDLE:  r_cnt <= '0;
                ST_LOAD: begin
                    r_cnt <= r_cnt[CHAIN_BITS] ? '0 : r_cnt + 1'b1;
                    r_sub <= '0;
                    r_rep <= '0;
                end
                ST_W6: begin
                    r_link <= r_last;
                    r_fwd  <= 1'b0;
                end
                ST_FE:   if (r_link == r_last) r_link <= lk_idx;
                ST_FG:   r_link <= lk_idx;
                ST_PD:   r_link <= '0;
                ST_XC: begin
                    r_acc <= asat;
                    if (r_link == r_last) begin
                        r_link <= '0;
                        r_fwd  <= 1'b1;
                    end else begin
                        r_link <= r_link + 1'b1;
                    end
                end
                ST_NEXT: begin
                    if (r_sub == SY_LAST[r_sel]) begin
                        r_sub <= '0;
                        r_rep <= r_rep + 5'd1;
                    end else begin
                        r_sub <= r_sub + 4'd1;
                    end
                end
                ST_STORE: r_cnt <= r_cnt + 1'b1;
                default: ;
            endcase
        end
    end

    // item payload, chain values and substep factors
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_dof  <= i_s_axis_tdata[9:0];
                r_p    <= i_s_axis_tdata[41:10];
                r_im   <= i_s_axis_tdata[73:42];
                r_last <= CHAIN_BITS'(clamp_n - 4'd1);
                r_sel  <= (r_sy_order > 3'd4) ? 3'd4 : r_sy_order;
                r_reps <= (r_nh_steps > 5'd16) ? 5'd16 : r_nh_steps;
            end
            ST_LOAD: begin
                if (r_cnt[CHAIN_BITS:0] != '0) begin
                    r_q[CHAIN_BITS'(r_cnt[CHAIN_BITS:0] - 1'b1)] <= mem_rdata;
                end
            end
            ST_W1:  r_w      <= mres;
            ST_W2:  r_fscale <= mres;
            ST_W3:  r_fshift <= mres;
            ST_W5:  r_fpart  <= mres;
            ST_W6:  r_fpos   <= mres;
            ST_LW:  r_fe     <= exp_f;
            ST_LE:  r_q[r_link] <= mres;
            ST_FC:  r_force  <= fsat;
            ST_FE:  r_q[r_link] <= qsat;
            ST_FG:  r_q[r_link] <= mres;
            ST_PD:  r_p      <= mres;
            default: ;
        endcase
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && (!r_out_valid || i_m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_out_valid || i_m_axis_tready)) begin
            r_out_mom <= r_p;
            r_out_pos <= r_acc;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_pos, r_out_mom};

    `NHC_ASSERT_NXT(a_one_item, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready,
        "second request accepted while an item is in work")
    `NHC_ASSERT_NXT(a_exp_wait, exp_start, r_state == ST_LW || r_state == ST_PW,
        "exp started outside a wait sequence")
    `NHC_ASSERT_IMP(a_link_range, r_state == ST_FE, r_link <= r_last,
        "link index beyond chain length")

endmodule

`default_nettype wire
